[design/msi_coh_pkg.sv]
// msi_coh_pkg: shared types for the msi snooping coherence block
// line states, bus message codes and sequencer states
// no dependencies
`timescale 1ns / 1ps

package msi_coh_pkg;

    typedef enum logic [1:0] {
        LS_I = 2'd0,
        LS_S = 2'd1,
        LS_M = 2'd2
    } line_st_t;

    typedef enum logic [1:0] {
        BUS_NONE  = 2'd0,
        BUS_RMISS = 2'd1,
        BUS_WMISS = 2'd2,
        BUS_INV   = 2'd3
    } bus_msg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_OWN_RD,
        S_OWN_EV,
        S_SCAN,
        S_FINISH
    } seq_st_t;

    localparam logic OP_WRITE = 1'b1;

endpackage

[design/msi_snooping_coherence.sv]
// msi_snooping_coherence: msi line state tracking for direct-mapped caches on a snooping bus
// one tag/state memory walked by a small sequencer with one shared compare path
// depends on msi_coh_pkg
//
// request channel: req_valid / req_stall with op, cpu, address. response channel:
// rsp_valid / rsp_stall with hit, bus message, new state, writeback and mask fields.
// an item is taken when valid is high and stall is low at a rising clock edge.
// one item is worked on at a time; req_stall stays high until the sequencer is idle.
// steps per item: the requester's own entry is read (S_OWN_RD), then checked (S_OWN_EV),
// and the result is loaded into the response register (S_FINISH), which waits while the
// output register is still held by a stalled response. a bus message adds a snoop of every
// cache's entry in S_SCAN (one cache entry per cycle through the single memory port);
// LINES_PER_CACHE other than a power of two adds index reduction (S_MOD) in front.
// the next item is taken in S_IDLE, once the response has been loaded.
// the response is held in an output register; a stalled response keeps its
// value and the next item is already taken and worked on behind it.
// after reset the block clears the state memory, one entry per cycle, over
// NUM_CACHES rounded up to a power of two times LINES_PER_CACHE rounded up to a
// power of two entries (16 with defaults); req_stall is high during that pass.
`timescale 1ns / 1ps

module msi_snooping_coherence
    import msi_coh_pkg::*;
#(
    parameter int NUM_CACHES      = 4,
    parameter int LINES_PER_CACHE = 4,
    parameter int ADDR_BITS       = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        op,
    input  logic [1:0]  cpu,
    input  logic [15:0] address,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        hit,
    output logic [1:0]  bus_message,
    output logic [1:0]  new_state,
    output logic        local_writeback,
    output logic [15:0] evicted_address,
    output logic        remote_writeback,
    output logic [1:0]  remote_cache,
    output logic [3:0]  downgraded_mask,
    output logic [3:0]  invalidated_mask
);

    localparam int CW       = $clog2(NUM_CACHES);
    localparam int IW       = (LINES_PER_CACHE > 1) ? $clog2(LINES_PER_CACHE) : 1;
    localparam int MW       = CW + IW;
    localparam int DEPTH    = 1 << MW;
    localparam int EW       = 2 + ADDR_BITS;
    localparam int PW       = 2 * ADDR_BITS;
    localparam bit IS_POW2  = ((LINES_PER_CACHE & (LINES_PER_CACHE - 1)) == 0);
    localparam logic [ADDR_BITS-1:0] RECIP =
        ADDR_BITS'((64'd1 << ADDR_BITS) / 64'(LINES_PER_CACHE));

    // tag and state memory, entry = {state, line address}
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] mem_rd_reg;
    logic          mem_we;
    logic [MW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [MW-1:0] mem_raddr;

    seq_st_t st_reg, st_next;
    logic [MW-1:0] clr_reg, clr_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic                 op_reg, op_next;
    logic [CW-1:0]        me_reg, me_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [ADDR_BITS-1:0] quo_reg, quo_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic                 cnt_reg, cnt_next;
    logic [CW-1:0]        scan_reg, scan_next;

    logic                 hit_reg, hit_next;
    bus_msg_t             bus_reg, bus_next;
    line_st_t             nst_reg, nst_next;
    logic                 lwb_reg, lwb_next;
    logic [ADDR_BITS-1:0] evict_reg, evict_next;
    logic                 rwb_reg, rwb_next;
    logic [CW-1:0]        rcache_reg, rcache_next;
    logic [3:0]           down_reg, down_next;
    logic [3:0]           inval_reg, inval_next;

    logic                 o_hit_reg, o_hit_next;
    bus_msg_t             o_bus_reg, o_bus_next;
    line_st_t             o_nst_reg, o_nst_next;
    logic                 o_lwb_reg, o_lwb_next;
    logic [15:0]          o_evict_reg, o_evict_next;
    logic                 o_rwb_reg, o_rwb_next;
    logic [1:0]           o_rcache_reg, o_rcache_next;
    logic [3:0]           o_down_reg, o_down_next;
    logic [3:0]           o_inval_reg, o_inval_next;

    logic                 accept;
    logic                 out_free;
    logic [ADDR_BITS-1:0] addr_in;
    logic [4:0]           cpu_ext;
    logic [CW-1:0]        me_in;
    logic [PW-1:0]        prod;
    logic [ADDR_BITS-1:0] quo_est;
    logic [IW:0]          rem_est;
    line_st_t             q_st;
    logic [ADDR_BITS-1:0] q_addr;
    logic                 q_match;
    logic                 own_hit;
    bus_msg_t             own_bus;
    logic                 scan_last;

    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign addr_in   = ADDR_BITS'(address);
    assign cpu_ext   = 5'(cpu);
    assign me_in     = (cpu_ext >= 5'(NUM_CACHES)) ? CW'(cpu_ext - 5'(NUM_CACHES))
                                                   : CW'(cpu_ext);
    assign q_st      = line_st_t'(mem_rd_reg[EW-1 -: 2]);
    assign q_addr    = mem_rd_reg[ADDR_BITS-1:0];
    assign q_match   = (q_st != LS_I) && (q_addr == addr_reg);
    assign own_hit   = q_match;
    assign scan_last = (scan_reg == CW'(NUM_CACHES - 1));
    // quotient by reciprocal multiplication, at most one short of the true one,
    // so the remainder estimate needs a single compare and subtract
    assign prod      = PW'(addr_reg) * PW'(RECIP);
    assign quo_est   = prod[PW-1:ADDR_BITS];
    assign rem_est   = (IW + 1)'(addr_reg)
                     - (IW + 1)'(quo_reg) * (IW + 1)'(LINES_PER_CACHE);

    always_comb
    begin
        if (!own_hit)
            own_bus = (op_reg == OP_WRITE) ? BUS_WMISS : BUS_RMISS;
        else if (op_reg == OP_WRITE && q_st == LS_S)
            own_bus = BUS_INV;
        else
            own_bus = BUS_NONE;
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_CLEAR:
            begin
                if (clr_reg == MW'(DEPTH - 1))
                    st_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                    st_next = IS_POW2 ? S_OWN_RD : S_MOD;
            end
            S_MOD:
            begin
                if (cnt_reg)
                    st_next = S_OWN_RD;
            end
            S_OWN_RD:
                st_next = S_OWN_EV;
            S_OWN_EV:
                st_next = (own_bus == BUS_NONE) ? S_FINISH : S_SCAN;
            S_SCAN:
            begin
                if (scan_last)
                    st_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                    st_next = S_IDLE;
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    // sequencer outputs: handshake and memory port control
    always_comb
    begin
        req_stall = (st_reg != S_IDLE);
        mem_we    = 1'b0;
        mem_waddr = {scan_reg, idx_reg};
        mem_wdata = mem_rd_reg;
        mem_re    = 1'b0;
        mem_raddr = {me_reg, idx_reg};
        case (st_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {LS_I, ADDR_BITS'(0)};
            end
            S_OWN_RD:
                mem_re = 1'b1;
            S_OWN_EV:
            begin
                mem_re    = 1'b1;
                mem_raddr = {CW'(0), idx_reg};
            end
            S_SCAN:
            begin
                mem_re    = !scan_last;
                mem_raddr = {CW'(scan_reg + CW'(1)), idx_reg};
                if (scan_reg == me_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {nst_reg, addr_reg};
                end
                else if (q_match)
                begin
                    mem_we    = 1'b1;
                    if (bus_reg == BUS_RMISS)
                        mem_wdata = {((q_st == LS_M) ? LS_S : q_st), q_addr};
                    else
                        mem_wdata = {LS_I, q_addr};
                end
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        op_next        = op_reg;
        me_next        = me_reg;
        addr_next      = addr_reg;
        quo_next       = quo_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        hit_next       = hit_reg;
        bus_next       = bus_reg;
        nst_next       = nst_reg;
        lwb_next       = lwb_reg;
        evict_next     = evict_reg;
        rwb_next       = rwb_reg;
        rcache_next    = rcache_reg;
        down_next      = down_reg;
        inval_next     = inval_reg;
        o_hit_next     = o_hit_reg;
        o_bus_next     = o_bus_reg;
        o_nst_next     = o_nst_reg;
        o_lwb_next     = o_lwb_reg;
        o_evict_next   = o_evict_reg;
        o_rwb_next     = o_rwb_reg;
        o_rcache_next  = o_rcache_reg;
        o_down_next    = o_down_reg;
        o_inval_next   = o_inval_reg;

        case (st_reg)
            S_CLEAR:
                clr_next = MW'(clr_reg + MW'(1));
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op;
                    me_next   = me_in;
                    addr_next = addr_in;
                    cnt_next  = 1'b0;
                    idx_next  = IS_POW2 ? (IW'(addr_in) & IW'(LINES_PER_CACHE - 1)) : '0;
                end
            end
            S_MOD:
            begin
                cnt_next = 1'b1;
                if (!cnt_reg)
                    quo_next = quo_est;
                else if (rem_est >= (IW + 1)'(LINES_PER_CACHE))
                    idx_next = IW'(rem_est - (IW + 1)'(LINES_PER_CACHE));
                else
                    idx_next = IW'(rem_est);
            end
            S_OWN_EV:
            begin
                hit_next    = own_hit;
                bus_next    = own_bus;
                lwb_next    = !own_hit && (q_st == LS_M);
                evict_next  = (!own_hit && (q_st == LS_M)) ? q_addr : '0;
                if (own_bus == BUS_NONE)
                    nst_next = q_st;
                else
                    nst_next = (op_reg == OP_WRITE) ? LS_M : LS_S;
                rwb_next    = 1'b0;
                rcache_next = '0;
                down_next   = '0;
                inval_next  = '0;
                scan_next   = '0;
            end
            S_SCAN:
            begin
                scan_next = CW'(scan_reg + CW'(1));
                if (scan_reg != me_reg && q_match)
                begin
                    if (bus_reg == BUS_RMISS)
                    begin
                        if (q_st == LS_M)
                        begin
                            rwb_next    = 1'b1;
                            rcache_next = scan_reg;
                            down_next   = down_reg | (4'b0001 << scan_reg);
                        end
                    end
                    else
                    begin
                        if (q_st == LS_M)
                        begin
                            rwb_next    = 1'b1;
                            rcache_next = scan_reg;
                        end
                        inval_next = inval_reg | (4'b0001 << scan_reg);
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    o_hit_next     = hit_reg;
                    o_bus_next     = bus_reg;
                    o_nst_next     = nst_reg;
                    o_lwb_next     = lwb_reg;
                    o_evict_next   = 16'(evict_reg);
                    o_rwb_next     = rwb_reg;
                    o_rcache_next  = 2'(rcache_reg);
                    o_down_next    = down_reg;
                    o_inval_next   = inval_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        me_reg       <= me_next;
        addr_reg     <= addr_next;
        quo_reg      <= quo_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        scan_reg     <= scan_next;
        hit_reg      <= hit_next;
        bus_reg      <= bus_next;
        nst_reg      <= nst_next;
        lwb_reg      <= lwb_next;
        evict_reg    <= evict_next;
        rwb_reg      <= rwb_next;
        rcache_reg   <= rcache_next;
        down_reg     <= down_next;
        inval_reg    <= inval_next;
        o_hit_reg    <= o_hit_next;
        o_bus_reg    <= o_bus_next;
        o_nst_reg    <= o_nst_next;
        o_lwb_reg    <= o_lwb_next;
        o_evict_reg  <= o_evict_next;
        o_rwb_reg    <= o_rwb_next;
        o_rcache_reg <= o_rcache_next;
        o_down_reg   <= o_down_next;
        o_inval_reg  <= o_inval_next;
    end

    // state memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rd_reg <= mem[mem_raddr];
    end

    assign rsp_valid        = rsp_valid_reg;
    assign hit              = o_hit_reg;
    assign bus_message      = o_bus_reg;
    assign new_state        = o_nst_reg;
    assign local_writeback  = o_lwb_reg;
    assign evicted_address  = o_evict_reg;
    assign remote_writeback = o_rwb_reg;
    assign remote_cache     = o_rcache_reg;
    assign downgraded_mask  = o_down_reg;
    assign invalidated_mask = o_inval_reg;

endmodule

[tb/sv/tb_msi_snooping_coherence.sv]
// tb_msi_snooping_coherence: self-checking bench for the msi snooping coherence block
// tracks every cache line in its own copy of the msi state and checks each response
// depends on msi_coh_pkg and msi_snooping_coherence
`timescale 1ns / 1ps

module tb_msi_snooping_coherence
    import msi_coh_pkg::*;
();

    localparam int   CACHES     = 4;
    localparam int   LINES      = 4;
    localparam int   IDLE_LIMIT = 2000;
    localparam int   TAIL_WAIT  = 30;
    localparam int   PRINT_CAP  = 60;
    localparam logic OP_READ    = 1'b0;

    typedef struct packed {
        logic       hit;
        bus_msg_t   bus;
        line_st_t   st;
        logic       lwb;
        logic [15:0] evicted;
        logic       rwb;
        logic [1:0] rcache;
        logic [3:0] down;
        logic [3:0] inval;
    } coh_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        op = 1'b0;
    logic [1:0]  cpu = 2'd0;
    logic [15:0] address = 16'd0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic        hit;
    logic [1:0]  bus_message;
    logic [1:0]  new_state;
    logic        local_writeback;
    logic [15:0] evicted_address;
    logic        remote_writeback;
    logic [1:0]  remote_cache;
    logic [3:0]  downgraded_mask;
    logic [3:0]  invalidated_mask;

    line_st_t    cache_state [CACHES][LINES];
    logic [15:0] cache_tag [CACHES][LINES];
    coh_result_t pending_outcomes [$];

    int   mismatch_count = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    bit   rsp_taken = 1'b0;
    bit   idling = 1'b1;

    msi_snooping_coherence dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .op               (op),
        .cpu              (cpu),
        .address          (address),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .hit              (hit),
        .bus_message      (bus_message),
        .new_state        (new_state),
        .local_writeback  (local_writeback),
        .evicted_address  (evicted_address),
        .remote_writeback (remote_writeback),
        .remote_cache     (remote_cache),
        .downgraded_mask  (downgraded_mask),
        .invalidated_mask (invalidated_mask)
    );

    always #4 clk = ~clk;

    // msi transition of one access across all caches at the addressed index
    function automatic coh_result_t predict_coherence(logic wr, logic [1:0] who,
                                                      logic [15:0] addr);
        coh_result_t r;
        int          idx;
        line_st_t    mine;
        line_st_t    st;
        r = '0;
        idx = addr % LINES;
        mine = cache_state[who][idx];
        r.hit = (mine != LS_I) && (cache_tag[who][idx] == addr);
        r.bus = BUS_NONE;
        if (!r.hit)
        begin
            r.bus = (wr == OP_WRITE) ? BUS_WMISS : BUS_RMISS;
            if (mine == LS_M)
            begin
                r.lwb = 1'b1;
                r.evicted = cache_tag[who][idx];
            end
        end
        else if (wr == OP_WRITE && mine == LS_S)
        begin
            r.bus = BUS_INV;
        end
        if (r.bus != BUS_NONE)
        begin
            for (int c = 0; c < CACHES; c++)
            begin
                st = cache_state[c][idx];
                if (c == who || st == LS_I || cache_tag[c][idx] != addr)
                    continue;
                if (r.bus == BUS_RMISS)
                begin
                    if (st == LS_M)
                    begin
                        cache_state[c][idx] = LS_S;
                        r.rwb = 1'b1;
                        r.rcache = c[1:0];
                        r.down[c] = 1'b1;
                    end
                end
                else
                begin
                    if (st == LS_M)
                    begin
                        r.rwb = 1'b1;
                        r.rcache = c[1:0];
                    end
                    cache_state[c][idx] = LS_I;
                    r.inval[c] = 1'b1;
                end
            end
            cache_state[who][idx] = (wr == OP_WRITE) ? LS_M : LS_S;
            cache_tag[who][idx] = addr;
        end
        r.st = cache_state[who][idx];
        return r;
    endfunction

    function automatic int draw_wait();
        if (!idling || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_field(string what, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // drives one access and records its expected outcome once it is taken
    task automatic send_access(logic wr, logic [1:0] who, logic [15:0] addr);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        op        <= wr;
        cpu       <= who;
        address   <= addr;
        do
            @(posedge clk);
        while (req_stall);
        pending_outcomes.push_back(predict_coherence(wr, who, addr));
    endtask

    // response stall, drawn again after every taken item
    always @(negedge clk)
    begin
        if (rsp_taken)
        begin
            rsp_taken = 1'b0;
            stall_left = draw_wait();
        end
        rsp_stall <= (stall_left > 0);
        if (stall_left > 0)
            stall_left--;
    end

    always @(posedge clk)
    begin
        coh_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_taken = 1'b1;
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("unexpected response", 0, 0);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                compare_field("hit", hit, want.hit);
                compare_field("bus_message", bus_message, want.bus);
                compare_field("new_state", new_state, want.st);
                compare_field("local_writeback", local_writeback, want.lwb);
                compare_field("evicted_address", evicted_address, want.evicted);
                compare_field("remote_writeback", remote_writeback, want.rwb);
                compare_field("remote_cache", remote_cache, want.rcache);
                compare_field("downgraded_mask", downgraded_mask, want.down);
                compare_field("invalidated_mask", invalidated_mask, want.inval);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // sharing, upgrade, downgrade, eviction and extreme addresses and cpus
    task automatic test_directed();
        send_access(OP_READ,  2'd0, 16'h0000);   // cold read miss
        send_access(OP_READ,  2'd0, 16'h0000);   // read hit
        send_access(OP_READ,  2'd1, 16'h0000);
        send_access(OP_READ,  2'd2, 16'h0000);
        send_access(OP_WRITE, 2'd0, 16'h0000);   // upgrade from s, two sharers dropped
        send_access(OP_WRITE, 2'd0, 16'h0000);   // write hit in m
        send_access(OP_READ,  2'd3, 16'h0000);   // remote m downgraded
        send_access(OP_WRITE, 2'd1, 16'h0000);   // write miss over two sharers
        send_access(OP_WRITE, 2'd2, 16'h0000);   // write miss over remote m
        send_access(OP_WRITE, 2'd2, 16'h0004);   // evicts own modified line
        send_access(OP_WRITE, 2'd3, 16'hFFFF);
        send_access(OP_READ,  2'd3, 16'hFFFF);
        send_access(OP_WRITE, 2'd0, 16'hFFFF);
        send_access(OP_READ,  2'd0, 16'hFFFB);   // victim at top address written back
        send_access(OP_READ,  2'd1, 16'hFFFB);
        send_access(OP_READ,  2'd2, 16'hFFFB);
        send_access(OP_WRITE, 2'd3, 16'hFFFB);
        send_access(OP_READ,  2'd3, 16'hAAAA);
        send_access(OP_WRITE, 2'd1, 16'h5555);
        send_access(OP_WRITE, 2'd1, 16'h8001);   // evicts 5555 from cache 1
        send_access(OP_READ,  2'd0, 16'h7FFE);
    endtask

    // most traffic goes to a small shifting pool so that lines are shared and contended
    task automatic test_shared_pool(int count);
        logic [15:0] pool [8];
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                foreach (pool[k])
                    pool[k] = 16'($urandom);
            end
            if ($urandom_range(0, 9) == 0)
                send_access(1'($urandom), 2'($urandom), 16'($urandom));
            else
                send_access(1'($urandom), 2'($urandom), pool[$urandom_range(0, 7)]);
        end
    endtask

    task automatic test_random_addresses(int count);
        for (int n = 0; n < count; n++)
            send_access(1'($urandom), 2'($urandom), 16'($urandom));
    endtask

    task automatic test_back_to_back(int count);
        idling = 1'b0;
        test_shared_pool(count);
        idling = 1'b1;
    endtask

    initial
    begin
        foreach (cache_state[c, l])
        begin
            cache_state[c][l] = LS_I;
            cache_tag[c][l] = 16'h0000;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_shared_pool(600);
        test_back_to_back(150);
        test_random_addresses(200);
        test_shared_pool(150);

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
